// ===== rtl/core/t0apdu_pkg.sv =====
package t0apdu_pkg;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_TO   = 2'd1,
		DIR_FROM = 2'd2
	} dir_t;

	localparam logic [7:0] BYTE_NULL   = 8'h60;
	localparam logic [7:0] NIB_MASK    = 8'hF0;
	localparam logic [7:0] SW1_HI_6X   = 8'h60;
	localparam logic [7:0] SW1_HI_9X   = 8'h90;
	localparam logic [7:0] SW1_CC      = 8'hCC;
	localparam logic [7:0] INV_MASK    = 8'hFF;
	localparam logic [7:0] INS_SELECT  = 8'hA4;
	localparam logic [2:0] HDR_MAX     = 3'd6;
	localparam logic [2:0] HDR_INS     = 3'd2;
	localparam logic [2:0] HDR_P1      = 3'd3;
	localparam logic [2:0] HDR_P3      = 3'd5;
	localparam logic [8:0] LEN_ZERO_AS = 9'd256;
	localparam logic [8:0] MOVED_MAX   = 9'd511;

endpackage

// ===== rtl/core/t0apdu_dir_decode.sv =====
module t0apdu_dir_decode
	import t0apdu_pkg::*;
(
	input  logic [7:0] ins,
	input  logic [7:0] p1,
	output dir_t       dir
);

	always_comb begin
		case (ins)
			8'h04, 8'h0E, 8'h0F, 8'h20, 8'h21, 8'h22,
			8'h24, 8'h26, 8'h28, 8'h2C, 8'h44, 8'h82,
			8'h86, 8'h87, 8'h88, 8'hA1, 8'hA2, 8'hA8,
			8'hAE, 8'hB1, 8'hB3, 8'hC2, 8'hC3, 8'hCB,
			8'hD0, 8'hD1, 8'hD2, 8'hD6, 8'hD7, 8'hDA,
			8'hDB, 8'hDC, 8'hDD, 8'hE0, 8'hE2, 8'hE4: dir = DIR_TO;
			8'h70, 8'h84, 8'hB0, 8'hB2, 8'hC0, 8'hCA: dir = DIR_FROM;
			INS_SELECT: begin
				case (p1)
					8'h01, 8'h02, 8'h04, 8'h08, 8'h09: dir = DIR_TO;
					8'h03:                             dir = DIR_FROM;
					default:                           dir = DIR_NONE;
				endcase
			end
			default: dir = DIR_NONE;
		endcase
	end

endmodule

// ===== rtl/core/t0apdu_fsm.sv =====
module t0apdu_fsm
	import t0apdu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] line_byte,
	output logic [1:0] mark
);

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_PROC   = 3'd1,
		PH_SW2    = 3'd2,
		PH_ALL    = 3'd3,
		PH_ONE    = 3'd4
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] hdr_cnt_q, hdr_cnt_d;
	logic [7:0] ins_q, ins_d;
	logic [7:0] p1_q, p1_d;
	logic [8:0] send_len_q, send_len_d;
	logic [8:0] exp_len_q, exp_len_d;
	logic [8:0] moved_q, moved_d;
	logic [8:0] moved_inc;
	logic       more;
	logic       is_sw1;
	dir_t       dir;

	t0apdu_dir_decode u_dir (
		.ins (ins_q),
		.p1  (p1_q),
		.dir (dir)
	);

	assign moved_inc = (moved_q < MOVED_MAX) ? moved_q + 9'd1 : moved_q;
	assign more      = (moved_q < send_len_q) || (moved_q < exp_len_q);
	assign is_sw1    = ((line_byte & NIB_MASK) == SW1_HI_6X) ||
	                   ((line_byte & NIB_MASK) == SW1_HI_9X) || (line_byte == SW1_CC);

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		ins_d      = ins_q;
		p1_d       = p1_q;
		send_len_d = send_len_q;
		exp_len_d  = exp_len_q;
		moved_d    = moved_q;
		mark       = DIR_NONE;
		case (phase_q)
			PH_PROC: begin
				if (line_byte == BYTE_NULL) begin
					mark = DIR_FROM;
				end else if (is_sw1) begin
					phase_d = PH_SW2;
				end else if (line_byte == ins_q) begin
					if (more)
						phase_d = PH_ALL;
					mark = DIR_FROM;
				end else if ((line_byte ^ INV_MASK) == ins_q) begin
					if (more)
						phase_d = PH_ONE;
					mark = DIR_FROM;
				end
			end
			PH_SW2: begin
				phase_d   = PH_HEADER;
				hdr_cnt_d = 3'd0;
				moved_d   = 9'd0;
				mark      = DIR_FROM;
			end
			PH_ALL: begin
				moved_d = moved_inc;
				if (dir == DIR_TO && moved_inc == send_len_q) begin
					phase_d = PH_PROC;
					mark    = DIR_TO;
				end else if (dir == DIR_FROM && moved_inc == exp_len_q) begin
					phase_d = PH_PROC;
					mark    = DIR_FROM;
				end
			end
			PH_ONE: begin
				moved_d = moved_inc;
				phase_d = PH_PROC;
				mark    = dir;
			end
			default: begin
				if (hdr_cnt_q < HDR_MAX)
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_d == HDR_INS) begin
					ins_d = line_byte;
				end else if (hdr_cnt_d == HDR_P1) begin
					p1_d = line_byte;
				end else if (hdr_cnt_d == HDR_P3) begin
					if (dir == DIR_FROM) begin
						exp_len_d  = (line_byte == 8'd0) ? LEN_ZERO_AS : {1'b0, line_byte};
						send_len_d = 9'd0;
						phase_d    = PH_PROC;
					end else if (dir == DIR_TO) begin
						send_len_d = {1'b0, line_byte};
						exp_len_d  = 9'd0;
						phase_d    = PH_PROC;
					end
					mark = DIR_TO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= 3'd0;
			ins_q      <= 8'd0;
			p1_q       <= 8'd0;
			send_len_q <= 9'd0;
			exp_len_q  <= 9'd0;
			moved_q    <= 9'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			ins_q      <= ins_d;
			p1_q       <= p1_d;
			send_len_q <= send_len_d;
			exp_len_q  <= exp_len_d;
			moved_q    <= moved_d;
		end
	end

endmodule

// ===== rtl/core/t0_apdu_exchange_tracker_core.sv =====
// Result path: the accepted byte passes through the input register, then the result register.
// Throughput: 1 request per cycle while the output is not stalled; tracker state is updated in the single decode stage.
// Stalls on the output hold the result register and back up into the input register.
// Reset (arst_n, async, active low): header phase, all counters and lengths cleared,
// both pipeline stages empty.
module t0_apdu_exchange_tracker_core
	import t0apdu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] line_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] byte_mark
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;
	logic [1:0] mark;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	t0apdu_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.line_byte (byte_s1),
		.mark      (mark)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= line_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			byte_mark <= mark;
	end

endmodule
